// File: rtl/core/integer_key_hash_unit_macros.svh
// Assertion macros used by the port checker of the integer key hash unit.
`ifndef INTEGER_KEY_HASH_UNIT_MACROS_SVH
`define INTEGER_KEY_HASH_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IKH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IKH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ikh_pkg.sv
// Shared types, codes, constants and mix functions of the integer key hash unit.
package ikh_pkg;

   localparam int unsigned KEY_BITS  = 64;
   localparam int unsigned HASH_BITS = 32;

   localparam logic [HASH_BITS-1:0] MULT_CONST = 32'h9E37_79B1;

   localparam logic [1:0] CSR_KEY_WIDTH       = 2'd0;
   localparam logic [1:0] CSR_FUNCTION_SELECT = 2'd1;
   localparam logic [1:0] CSR_BUCKET_MASK     = 2'd2;

   localparam logic [1:0] KEY_WIDTH_8  = 2'd0;
   localparam logic [1:0] KEY_WIDTH_16 = 2'd1;
   localparam logic [1:0] KEY_WIDTH_32 = 2'd2;
   localparam logic [1:0] KEY_WIDTH_64 = 2'd3;

   // Function codes for 8-bit keys.
   localparam logic [1:0] FN8_IDENTITY      = 2'd0;
   localparam logic [1:0] FN8_MULT          = 2'd1;
   localparam logic [1:0] FN8_ADD_MIX       = 2'd2;
   localparam logic [1:0] FN8_XOR_MIX       = 2'd3;

   // Function codes for 16, 32 and 64-bit keys.
   localparam logic [1:0] FN_MULT           = 2'd0;
   localparam logic [1:0] FN_ADD_MIX        = 2'd1;
   localparam logic [1:0] FN_XOR_MIX        = 2'd2;
   localparam logic [1:0] FN_UNSUPPORTED    = 2'd3;

   localparam logic [1:0]           KEY_WIDTH_RESET   = KEY_WIDTH_32;
   localparam logic [1:0]           FUNCTION_RESET    = 2'd0;
   localparam logic [HASH_BITS-1:0] BUCKET_MASK_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]           key_width;
      logic [1:0]           function_select;
      logic [HASH_BITS-1:0] bucket_mask;
   } cfg_type;

   typedef struct packed {
      logic [HASH_BITS-1:0] bucket_hash;
      logic                 unsupported;
   } result_type;

   function automatic logic [HASH_BITS-1:0] add_shift_mix(input logic [HASH_BITS-1:0] v);
      logic [HASH_BITS-1:0] a;
      a = v;
      a = (a + 32'h7ED5_5D16) + (a << 12);
      a = (a ^ 32'hC761_C23C) ^ (a >> 19);
      a = (a + 32'h1656_67B1) + (a << 5);
      a = (a + 32'hD3A2_646C) ^ (a << 9);
      a = (a + 32'hFD70_46C5) + (a << 3);
      a = (a ^ 32'hB55A_4F09) ^ (a >> 16);
      return a;
   endfunction

   function automatic logic [HASH_BITS-1:0] shift_xor_mix(input logic [HASH_BITS-1:0] v);
      logic [HASH_BITS-1:0] a;
      a = v;
      a = ~a + (a << 15);
      a = a ^ (a >> 12);
      a = a + (a << 2);
      a = a ^ (a >> 4);
      // Multiplication by 2057 is 1 + 8 + 2048.
      a = a + (a << 3) + (a << 11);
      a = a ^ (a >> 16);
      return a;
   endfunction

endpackage

// File: rtl/core/ikh_csr.sv
// Configuration registers of the integer key hash unit.
module ikh_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_index,
   input  logic [ikh_pkg::HASH_BITS-1:0]   csr_write_data,
   output ikh_pkg::cfg_type                cfg
);

   logic [1:0]                    key_width_ff, key_width_in;
   logic [1:0]                    function_select_ff, function_select_in;
   logic [ikh_pkg::HASH_BITS-1:0] bucket_mask_ff, bucket_mask_in;

   always_comb begin
      key_width_in       = key_width_ff;
      function_select_in = function_select_ff;
      bucket_mask_in     = bucket_mask_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ikh_pkg::CSR_KEY_WIDTH:       key_width_in       = csr_write_data[1:0];
            ikh_pkg::CSR_FUNCTION_SELECT: function_select_in = csr_write_data[1:0];
            ikh_pkg::CSR_BUCKET_MASK:     bucket_mask_in     = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_width_ff       <= ikh_pkg::KEY_WIDTH_RESET;
         function_select_ff <= ikh_pkg::FUNCTION_RESET;
         bucket_mask_ff     <= ikh_pkg::BUCKET_MASK_RESET;
      end else begin
         key_width_ff       <= key_width_in;
         function_select_ff <= function_select_in;
         bucket_mask_ff     <= bucket_mask_in;
      end
   end

   assign cfg.key_width       = key_width_ff;
   assign cfg.function_select = function_select_ff;
   assign cfg.bucket_mask     = bucket_mask_ff;

endmodule

// File: rtl/core/ikh_hash_core.sv
// Combinational hash datapath: key shaping, multiplicative hash, mix lanes and masking.
module ikh_hash_core (
   input  logic [ikh_pkg::KEY_BITS-1:0] key_value,
   input  ikh_pkg::cfg_type             cfg,
   output ikh_pkg::result_type          result
);

   logic [ikh_pkg::KEY_BITS-1:0]  mult_operand;
   logic [ikh_pkg::KEY_BITS-1:0]  mult_low_product;
   logic [15:0]                   mult_high_part;
   logic [ikh_pkg::HASH_BITS-1:0] mult_hash;
   logic [ikh_pkg::HASH_BITS-1:0] lane_lo;
   logic [ikh_pkg::HASH_BITS-1:0] lane_hi;
   logic [ikh_pkg::HASH_BITS-1:0] add_mix_lo, add_mix_hi;
   logic [ikh_pkg::HASH_BITS-1:0] xor_mix_lo, xor_mix_hi;
   logic [ikh_pkg::HASH_BITS-1:0] hash;
   logic                          unsupported;

   always_comb begin
      mult_operand = '0;
      lane_lo      = key_value[31:0];
      case (cfg.key_width)
         ikh_pkg::KEY_WIDTH_8: begin
            mult_operand[7:0] = key_value[7:0];
            lane_lo           = {4{key_value[7:0]}};
         end
         ikh_pkg::KEY_WIDTH_16: begin
            mult_operand[15:0] = key_value[15:0];
            lane_lo            = {2{key_value[15:0]}};
         end
         ikh_pkg::KEY_WIDTH_32: begin
            mult_operand[31:0] = key_value[31:0];
         end
         default: begin
            mult_operand = key_value;
         end
      endcase
   end

   assign lane_hi = key_value[63:32];

   // Only product bits 47:16 are kept, so the upper key half contributes
   // through a 16 by 16 product that lands on bits 47:32.
   assign mult_low_product = {32'd0, mult_operand[31:0]} * {32'd0, ikh_pkg::MULT_CONST};
   assign mult_high_part   = mult_operand[47:32] * ikh_pkg::MULT_CONST[15:0];
   assign mult_hash        = mult_low_product[47:16] + {mult_high_part, 16'd0};

   assign add_mix_lo = ikh_pkg::add_shift_mix(lane_lo);
   assign add_mix_hi = ikh_pkg::add_shift_mix(lane_hi);
   assign xor_mix_lo = ikh_pkg::shift_xor_mix(lane_lo);
   assign xor_mix_hi = ikh_pkg::shift_xor_mix(lane_hi);

   always_comb begin
      hash        = '0;
      unsupported = 1'b0;
      if (cfg.key_width == ikh_pkg::KEY_WIDTH_8) begin
         case (cfg.function_select)
            ikh_pkg::FN8_IDENTITY: hash = {24'd0, key_value[7:0]};
            ikh_pkg::FN8_MULT:     hash = mult_hash;
            ikh_pkg::FN8_ADD_MIX:  hash = add_mix_lo;
            default:               hash = xor_mix_lo;
         endcase
      end else begin
         case (cfg.function_select)
            ikh_pkg::FN_MULT: hash = mult_hash;
            ikh_pkg::FN_ADD_MIX: begin
               hash = add_mix_lo;
               if (cfg.key_width == ikh_pkg::KEY_WIDTH_64) begin
                  hash = add_mix_lo ^ add_mix_hi;
               end
            end
            ikh_pkg::FN_XOR_MIX: begin
               hash = xor_mix_lo;
               if (cfg.key_width == ikh_pkg::KEY_WIDTH_64) begin
                  hash = xor_mix_lo ^ xor_mix_hi;
               end
            end
            default: unsupported = 1'b1;
         endcase
      end
   end

   assign result.bucket_hash = hash & cfg.bucket_mask;
   assign result.unsupported = unsupported;

endmodule

// File: rtl/core/integer_key_hash_unit.sv
// Top level of the integer key hash unit: transfer registers around the hash datapath.
//
// The unit maps one integer key to a masked bucket index and takes one key in every
// cycle while the result side does not stall. The key is captured in an input
// register, the whole hash is computed in one pass through the datapath, and the
// masked value is held in a result register until it is taken.
// The throughput of one key per cycle, when the result side does not stall, is set
// by that single pass, which includes the 32 by 32 constant product of the
// multiplicative hash. When the result side stalls and the input register is empty,
// one more key is still accepted into it before req_stall rises. Configuration
// registers reset to a 32-bit key, the multiplicative function and an all-ones
// bucket mask; the user must write them only while no transfer is in flight, and
// the unit itself does not enforce this.
module integer_key_hash_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ikh_pkg::KEY_BITS-1:0]  req_key_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ikh_pkg::HASH_BITS-1:0] rsp_bucket_hash,
   output logic                          rsp_unsupported,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [ikh_pkg::HASH_BITS-1:0] csr_write_data
);

   ikh_pkg::cfg_type    cfg;
   ikh_pkg::result_type core_result;

   logic                         in_valid_ff, in_valid_in;
   logic [ikh_pkg::KEY_BITS-1:0] in_key_ff, in_key_in;
   logic                         out_valid_ff, out_valid_in;
   ikh_pkg::result_type          out_result_ff, out_result_in;
   logic                         out_advance;
   logic                         in_advance;

   ikh_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ikh_hash_core u_hash_core (
      .key_value (in_key_ff),
      .cfg       (cfg),
      .result    (core_result)
   );

   assign out_advance = !out_valid_ff || !rsp_stall;
   assign in_advance  = !in_valid_ff || out_advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_key_in     = in_key_ff;
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (in_advance) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_key_in = req_key_value;
         end
      end
      if (out_advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_result_in = core_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_key_ff     <= in_key_in;
      out_result_ff <= out_result_in;
   end

   assign req_stall       = !in_advance;
   assign rsp_valid       = out_valid_ff;
   assign rsp_bucket_hash = out_result_ff.bucket_hash;
   assign rsp_unsupported = out_result_ff.unsupported;

endmodule

// File: rtl/core/ikh_port_checker.sv
// Port-level checker of the integer key hash unit and its bind to the top level.
`include "integer_key_hash_unit_macros.svh"

module ikh_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ikh_pkg::HASH_BITS-1:0] rsp_bucket_hash,
   input logic                          rsp_unsupported
);

   logic req_transfer;

   assign req_transfer = req_valid && !req_stall;

   `IKH_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")
   `IKH_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled while result side can move")
   `IKH_ASSERT_SAME(a_unsupported_zero, clock, reset, rsp_valid && rsp_unsupported, rsp_bucket_hash == '0, "unsupported result carries a nonzero hash")
   `IKH_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall && !req_transfer, rsp_valid && $stable(rsp_bucket_hash) && $stable(rsp_unsupported), "stalled result changed")

endmodule

bind integer_key_hash_unit ikh_port_checker u_port_checker (.*);

// File: dv/integer_key_hash_unit_test.sv
// Self-checking testbench for the integer key hash unit: random and directed keys under backpressure.
module integer_key_hash_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned PHASE_COUNT   = 32;
   localparam int unsigned PHASE_KEYS    = 56;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [ikh_pkg::KEY_BITS-1:0]  req_key_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [ikh_pkg::HASH_BITS-1:0] rsp_bucket_hash;
   logic                          rsp_unsupported;
   logic                          csr_write_enable = 1'b0;
   logic [1:0]                    csr_index = ikh_pkg::CSR_KEY_WIDTH;
   logic [ikh_pkg::HASH_BITS-1:0] csr_write_data = '0;

   logic [ikh_pkg::KEY_BITS-1:0]  key_backlog[$];
   ikh_pkg::result_type           bucket_expected[$];
   ikh_pkg::cfg_type              table_cfg = '{ikh_pkg::KEY_WIDTH_RESET,
                                                ikh_pkg::FUNCTION_RESET,
                                                ikh_pkg::BUCKET_MASK_RESET};
   int unsigned          gap_pct = 0;
   int unsigned          stall_pct = 0;
   int unsigned          keys_queued = 0;
   int unsigned          keys_accepted = 0;
   int unsigned          cycle_count = 0;
   int unsigned          hold_left = 0;
   logic                 hold_request = 1'b0;
   logic                 hold_taken = 1'b0;
   logic                 req_fire = 1'b0;
   logic                 failed = 1'b0;

   integer_key_hash_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_key_value(req_key_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_bucket_hash(rsp_bucket_hash),
      .rsp_unsupported(rsp_unsupported),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [ikh_pkg::HASH_BITS-1:0] golden_product(
      input logic [ikh_pkg::KEY_BITS-1:0] v);
      logic [ikh_pkg::KEY_BITS-1:0] p;
      p = v * {32'd0, ikh_pkg::MULT_CONST};
      return p[47:16];
   endfunction

   function automatic logic [ikh_pkg::HASH_BITS-1:0] scramble_add(
      input logic [ikh_pkg::HASH_BITS-1:0] v);
      logic [ikh_pkg::HASH_BITS-1:0] a;
      a = v;
      a = (a + 32'h7ed55d16) + (a << 12);
      a = (a ^ 32'hc761c23c) ^ (a >> 19);
      a = (a + 32'h165667b1) + (a << 5);
      a = (a + 32'hd3a2646c) ^ (a << 9);
      a = (a + 32'hfd7046c5) + (a << 3);
      a = (a ^ 32'hb55a4f09) ^ (a >> 16);
      return a;
   endfunction

   function automatic logic [ikh_pkg::HASH_BITS-1:0] scramble_xor(
      input logic [ikh_pkg::HASH_BITS-1:0] v);
      logic [ikh_pkg::HASH_BITS-1:0] a;
      a = v;
      a = ~a + (a << 15);
      a = a ^ (a >> 12);
      a = a + (a << 2);
      a = a ^ (a >> 4);
      a = a * 32'd2057;
      a = a ^ (a >> 16);
      return a;
   endfunction

   function automatic ikh_pkg::result_type predict_bucket(
      input logic [ikh_pkg::KEY_BITS-1:0] key,
      input ikh_pkg::cfg_type cfg);
      logic [7:0]                    b;
      logic [15:0]                   w;
      logic [ikh_pkg::HASH_BITS-1:0] h;
      logic                          unsup;
      ikh_pkg::result_type           r;
      b = key[7:0];
      w = key[15:0];
      h = '0;
      unsup = 1'b0;
      case (cfg.key_width)
         ikh_pkg::KEY_WIDTH_8: begin
            case (cfg.function_select)
               ikh_pkg::FN8_IDENTITY: h = {24'd0, b};
               ikh_pkg::FN8_MULT:     h = golden_product({56'd0, b});
               ikh_pkg::FN8_ADD_MIX:  h = scramble_add({4{b}});
               default:               h = scramble_xor({4{b}});
            endcase
         end
         ikh_pkg::KEY_WIDTH_16: begin
            case (cfg.function_select)
               ikh_pkg::FN_MULT:    h = golden_product({48'd0, w});
               ikh_pkg::FN_ADD_MIX: h = scramble_add({2{w}});
               ikh_pkg::FN_XOR_MIX: h = scramble_xor({2{w}});
               default:             unsup = 1'b1;
            endcase
         end
         ikh_pkg::KEY_WIDTH_32: begin
            case (cfg.function_select)
               ikh_pkg::FN_MULT:    h = golden_product({32'd0, key[31:0]});
               ikh_pkg::FN_ADD_MIX: h = scramble_add(key[31:0]);
               ikh_pkg::FN_XOR_MIX: h = scramble_xor(key[31:0]);
               default:             unsup = 1'b1;
            endcase
         end
         default: begin
            case (cfg.function_select)
               ikh_pkg::FN_MULT:    h = golden_product(key);
               ikh_pkg::FN_ADD_MIX: h = scramble_add(key[31:0]) ^ scramble_add(key[63:32]);
               ikh_pkg::FN_XOR_MIX: h = scramble_xor(key[31:0]) ^ scramble_xor(key[63:32]);
               default:             unsup = 1'b1;
            endcase
         end
      endcase
      r.bucket_hash = unsup ? '0 : (h & cfg.bucket_mask);
      r.unsupported = unsup;
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[integer_key_hash_unit] ERROR");
         $finish;
      end
   end

   // A key transfer records its expected bucket under the configuration in force.
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         bucket_expected.push_back(predict_bucket(req_key_value, table_cfg));
         keys_accepted++;
      end
   end

   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_fire)) begin
         if (key_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
            req_valid <= 1'b1;
            req_key_value <= key_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      ikh_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bucket_expected.size() == 0) begin
            $error("bucket_hash: no result expected, actual %h", rsp_bucket_hash);
            failed = 1'b1;
         end else begin
            want = bucket_expected.pop_front();
            if (rsp_bucket_hash !== want.bucket_hash) begin
               $error("bucket_hash: expected %h, actual %h", want.bucket_hash, rsp_bucket_hash);
               failed = 1'b1;
            end
            if (rsp_unsupported !== want.unsupported) begin
               $error("unsupported: expected %b, actual %b", want.unsupported, rsp_unsupported);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic write_register(input logic [1:0] index,
                                 input logic [ikh_pkg::HASH_BITS-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [1:0] width, input logic [1:0] fsel,
                            input logic [ikh_pkg::HASH_BITS-1:0] mask);
      write_register(ikh_pkg::CSR_KEY_WIDTH, {30'd0, width});
      write_register(ikh_pkg::CSR_FUNCTION_SELECT, {30'd0, fsel});
      write_register(ikh_pkg::CSR_BUCKET_MASK, mask);
      table_cfg = '{width, fsel, mask};
   endtask

   task automatic offer_key(input logic [ikh_pkg::KEY_BITS-1:0] key);
      key_backlog.push_back(key);
      keys_queued++;
   endtask

   task automatic drain();
      while (keys_accepted != keys_queued || bucket_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [ikh_pkg::KEY_BITS-1:0]  key;
      logic [ikh_pkg::HASH_BITS-1:0] mask;
      int unsigned                   combo;
      int unsigned                   mode;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: 32-bit keys, multiplicative hash, full mask.
      offer_key('0);
      offer_key('1);
      offer_key(64'd1);
      offer_key(64'h8000_0000_0000_0000);
      offer_key(64'h0000_0000_FFFF_FFFF);
      offer_key(64'hFFFF_FFFF_0000_0000);
      offer_key(64'h0000_0000_8000_0000);
      offer_key(64'h0000_0000_0001_0000);
      drain();

      // The 64-bit product wraps and its shifted value is wider than the result.
      configure(ikh_pkg::KEY_WIDTH_64, ikh_pkg::FN_MULT, 32'hFFFF_FFFF);
      offer_key('1);
      offer_key(64'h8000_0000_0000_0000);
      offer_key(64'h0000_FFFF_FFFF_FFFF);
      offer_key(64'h1234_5678_9ABC_DEF0);
      drain();

      configure(ikh_pkg::KEY_WIDTH_16, ikh_pkg::FN_UNSUPPORTED, 32'hFFFF_FFFF);
      offer_key('1);
      offer_key('0);
      drain();

      configure(ikh_pkg::KEY_WIDTH_8, ikh_pkg::FN8_IDENTITY, 32'd0);
      offer_key('1);
      offer_key(64'h0000_0000_0000_0080);
      drain();

      for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
         combo = p % 16;
         mode = (p + p / 16) % 4;
         case (p % 5)
            0: mask = 32'hFFFF_FFFF;
            1: mask = 32'd0;
            3: mask = (32'd1 << $urandom_range(31)) - 32'd1;
            default: mask = $urandom;
         endcase
         configure(combo[3:2], combo[1:0], mask);
         case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 88; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 88; end
            default: begin gap_pct = 19; stall_pct = 19; end
         endcase
         if (p == 4)
            hold_request = 1'b1;
         for (int unsigned i = 0; i < PHASE_KEYS; i++) begin
            case ($urandom_range(7))
               0: key = '1;
               1: key = '0;
               2: key = 64'd1 << $urandom_range(63);
               default: key = {$urandom, $urandom};
            endcase
            offer_key(key);
         end
         drain();
      end

      gap_pct = 0;
      stall_pct = 0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (!failed && bucket_expected.size() == 0)
         $display("[integer_key_hash_unit] OK");
      else
         $display("[integer_key_hash_unit] ERROR");
      $finish;
   end

endmodule
